[sv/sia_pkg.sv]
// ----------------------------------------------------------------------------
// sia_pkg
// Shared constants and types of the sparse interval accumulator.
// ----------------------------------------------------------------------------
package sia_pkg;

	localparam int MaxRunsDefault   = 16;
	localparam int MaxValuesDefault = 64;
	localparam int IndexBitsDefault = 16;

	typedef enum logic [1:0] {
		OP_ACC   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_RSVD  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_FRONT   = 3'd1,
		ST_BACK    = 3'd2,
		ST_NEW     = 3'd3,
		ST_DROPPED = 3'd4,
		ST_HIT     = 3'd5,
		ST_MISS    = 3'd6,
		ST_CLEARED = 3'd7
	} status_t;

	// saturating signed 32-bit add
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		begin
			s = {a[31], a} + {b[31], b};
			if (s[32] != s[31]) sat_add = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
			else sat_add = s[31:0];
		end
	endfunction

endpackage

[sv/sparse_interval_accumulator_top.sv]
// A clear finishes directly; a read walks every held run and fetches the value of each
// run holding the index; an accumulate walks runs until a match and shifts the values
// above an insert point up by one.
// One request at a time (busy high); the next can be taken in the cycle done is high.
// Results appear for one cycle on done; the receiver cannot stall.
// Reset clears the counts and control; the memories need no clearing.
// ----------------------------------------------------------------------------
// sparse_interval_accumulator_top
// Sequencer over the run table and the value store.
// ----------------------------------------------------------------------------
module sparse_interval_accumulator_top
	import sia_pkg::*;
#(
	parameter int MAX_RUNS   = MaxRunsDefault,
	parameter int MAX_VALUES = MaxValuesDefault,
	parameter int INDEX_BITS = IndexBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [INDEX_BITS-1:0] windex,
	input  logic signed [31:0] value,
	output logic        done,
	output logic [2:0]  status,
	output logic signed [31:0] sum_out,
	output logic [4:0]  run_count,
	output logic [6:0]  value_count
);

	localparam int RA = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int VA = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
	localparam int RC = $clog2(MAX_RUNS + 1);
	localparam int VC = $clog2(MAX_VALUES + 1);
	localparam int LW = VC;
	localparam int IW = INDEX_BITS;
	localparam int PW = IW + 2;

	typedef enum logic [3:0] {
		S_IDLE, S_RREQ, S_RCHK, S_VREQ, S_VADD, S_SREQ, S_SMOV, S_PUT, S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] op_q;
	logic [IW-1:0] idx_q;
	logic [31:0] val_q, sum_q;
	logic [RC-1:0] runs_q, r_q;
	logic [VC-1:0] vals_q, base_q, pos_q, mv_q;
	logic hit_q;
	logic [2:0] st_q;

	// memory ports
	logic rm_we;
	logic [RA-1:0] rm_wa, rm_ra;
	logic [IW-1:0] rm_ws, rm_rs;
	logic [LW-1:0] rm_wl, rm_rl;
	logic vm_we;
	logic [VA-1:0] vm_wa, vm_ra;
	logic [31:0] vm_wd, vm_rd;

	sia_run_mem #(.DEPTH(MAX_RUNS), .AW(RA), .IW(IW), .LW(LW)) u_runs (
		.clk(clk), .we(rm_we), .waddr(rm_wa), .wstart(rm_ws), .wlen(rm_wl),
		.raddr(rm_ra), .rstart(rm_rs), .rlen(rm_rl)
	);

	sia_value_mem #(.DEPTH(MAX_VALUES), .AW(VA)) u_vals (
		.clk(clk), .we(vm_we), .waddr(vm_wa), .wdata(vm_wd),
		.raddr(vm_ra), .rdata(vm_rd)
	);

	// run window tests on the fetched run
	logic [PW-1:0] s_w, e_w, i_w;
	logic in_win, in_run, at_front;
	always_comb begin
		s_w = PW'(rm_rs);
		e_w = PW'(rm_rs) + PW'(rm_rl);
		i_w = PW'(idx_q);
		in_win = ((s_w == '0) || (s_w - 1'b1 <= i_w)) && (e_w >= i_w);
		in_run = (s_w <= i_w) && (i_w < e_w);
		at_front = (s_w != '0) && (s_w - 1'b1 == i_w);
	end

	logic [VC-1:0] off_w;
	assign off_w = VC'(idx_q - rm_rs);

	// memory addressing
	always_comb begin
		rm_ra = r_q[RA-1:0];
		vm_ra = (state_q == S_SREQ) ? VA'(mv_q - 1'b1) : pos_q[VA-1:0];
		vm_we = 1'b0;
		vm_wa = pos_q[VA-1:0];
		vm_wd = val_q;
		rm_we = 1'b0;
		rm_wa = r_q[RA-1:0];
		rm_ws = rm_rs;
		rm_wl = rm_rl;
		case (state_q)
			S_VADD: begin
				if (op_q == OP_ACC) begin
					vm_we = 1'b1;
					vm_wd = sat_add(vm_rd, val_q);
				end
			end
			S_SMOV: begin
				vm_we = 1'b1;
				vm_wa = mv_q[VA-1:0];
				vm_wd = vm_rd;
			end
			S_PUT: vm_we = 1'b1;
			S_RCHK: begin
				if (op_q == OP_ACC && r_q >= runs_q) begin
					rm_we = (runs_q < RC'(MAX_RUNS)) && (vals_q < VC'(MAX_VALUES));
					rm_wa = runs_q[RA-1:0];
					rm_ws = idx_q;
					rm_wl = LW'(1);
				end else if (op_q == OP_ACC && in_win && !in_run &&
						vals_q < VC'(MAX_VALUES)) begin
					rm_we = 1'b1;
					rm_ws = at_front ? rm_rs - 1'b1 : rm_rs;
					rm_wl = rm_rl + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			runs_q <= '0;
			vals_q <= '0;
			done <= 1'b0;
			op_q <= '0; idx_q <= '0; val_q <= '0; sum_q <= '0;
			r_q <= '0; base_q <= '0; pos_q <= '0; mv_q <= '0;
			hit_q <= 1'b0; st_q <= '0;
			status <= '0; sum_out <= '0; run_count <= '0; value_count <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= opcode;
						idx_q <= windex;
						val_q <= value;
						r_q <= '0; base_q <= '0; sum_q <= '0; hit_q <= 1'b0;
						if (opcode == OP_CLEAR) begin
							runs_q <= '0; vals_q <= '0;
							st_q <= ST_CLEARED;
							state_q <= S_DONE;
						end else state_q <= S_RREQ;
					end
				end
				S_RREQ: state_q <= S_RCHK;
				S_RCHK: begin
					if (r_q >= runs_q || r_q >= RC'(MAX_RUNS)) begin
						if (op_q != OP_ACC) begin
							st_q <= hit_q ? ST_HIT : ST_MISS;
							state_q <= S_DONE;
						end else if (runs_q >= RC'(MAX_RUNS) || vals_q >= VC'(MAX_VALUES)) begin
							st_q <= ST_DROPPED; sum_q <= '0; state_q <= S_DONE;
						end else begin
							runs_q <= runs_q + 1'b1;
							pos_q <= vals_q; mv_q <= vals_q;
							st_q <= ST_NEW; sum_q <= val_q;
							state_q <= S_PUT;
						end
					end else if (op_q == OP_ACC && in_win) begin
						if (in_run) begin
							pos_q <= base_q + off_w;
							st_q <= ST_ADDED;
							state_q <= S_VREQ;
						end else if (vals_q >= VC'(MAX_VALUES)) begin
							st_q <= ST_DROPPED; sum_q <= '0; state_q <= S_DONE;
						end else begin
							pos_q <= at_front ? base_q : base_q + VC'(rm_rl);
							mv_q <= vals_q;
							st_q <= at_front ? ST_FRONT : ST_BACK;
							sum_q <= val_q;
							state_q <= S_SREQ;
						end
					end else begin
						if (op_q != OP_ACC && in_run) begin
							pos_q <= base_q + off_w;
							state_q <= S_VREQ;
						end else begin
							state_q <= S_RREQ;
							r_q <= r_q + 1'b1;
						end
						base_q <= base_q + VC'(rm_rl);
					end
				end
				S_VREQ: state_q <= S_VADD;
				S_VADD: begin
					if (op_q == OP_ACC) begin
						sum_q <= sat_add(vm_rd, val_q);
						state_q <= S_DONE;
					end else begin
						if (pos_q < vals_q) begin
							sum_q <= sat_add(sum_q, vm_rd);
							hit_q <= 1'b1;
						end
						r_q <= r_q + 1'b1;
						state_q <= S_RREQ;
					end
				end
				S_SREQ: begin
					if (mv_q == pos_q) state_q <= S_PUT;
					else state_q <= S_SMOV;
				end
				S_SMOV: begin
					mv_q <= mv_q - 1'b1;
					state_q <= S_SREQ;
				end
				S_PUT: begin
					vals_q <= vals_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1;
					status <= st_q;
					sum_out <= (st_q == ST_MISS || st_q == ST_CLEARED) ? '0 : sum_q;
					run_count <= 5'(runs_q);
					value_count <= 7'(vals_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		runs_q <= RC'(MAX_RUNS) && vals_q <= VC'(MAX_VALUES))
		else $error("held counts beyond capacity");
	// a new run is counted on entering S_PUT, its value on leaving it
	a_runs_le_vals: assert property (@(posedge clk) disable iff (!arst_n)
		runs_q <= vals_q || state_q == S_PUT)
		else $error("more runs than values");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_CLEARED) |-> (run_count == '0 && value_count == '0))
		else $error("clear left counts");
`endif

endmodule

[sv/sia_value_mem.sv]
// ----------------------------------------------------------------------------
// sia_value_mem
// Packed value store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sia_value_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[sv/sia_run_mem.sv]
// ----------------------------------------------------------------------------
// sia_run_mem
// Run table: start and length per run, one write port, one registered read.
// ----------------------------------------------------------------------------
module sia_run_mem #(
	parameter int DEPTH = 16,
	parameter int AW = 4,
	parameter int IW = 16,
	parameter int LW = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [IW-1:0] wstart,
	input  logic [LW-1:0] wlen,
	input  logic [AW-1:0] raddr,
	output logic [IW-1:0] rstart,
	output logic [LW-1:0] rlen
);

	logic [IW+LW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= {wstart, wlen};
	end

	// registered read
	always_ff @(posedge clk) begin
		{rstart, rlen} <= mem[raddr];
	end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the sparse interval accumulator against a cycle-free predictor of
// its run table and value store, with bursty requests and random gaps.
// ----------------------------------------------------------------------------
module tb;
	import sia_pkg::*;

	localparam int NumRuns = MaxRunsDefault;
	localparam int NumVals = MaxValuesDefault;

	typedef struct packed {
		opcode_t     op;
		logic [15:0] idx;
		logic [31:0] val;
	} request_t;

	typedef struct packed {
		status_t     st;
		logic [31:0] sum;
		logic [4:0]  runs;
		logic [6:0]  vals;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [15:0] windex;
	logic [31:0] value;
	logic        done;
	logic [2:0]  status;
	logic [31:0] sum_out;
	logic [4:0]  run_count;
	logic [6:0]  value_count;

	// predictor state
	logic [15:0] pr_start [NumRuns];
	logic [6:0]  pr_len [NumRuns];
	logic [31:0] pr_vals [NumVals];
	int          pr_runs;
	int          pr_nvals;

	request_t pending [$];
	answer_t  expected [$];
	int       mismatches;
	int       gap_left;
	int       burst_left;
	bit       hold_off;

	sparse_interval_accumulator_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .windex(windex), .value(value),
		.done(done), .status(status), .sum_out(sum_out),
		.run_count(run_count), .value_count(value_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// own saturating add
	function automatic logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
		longint s;
		begin
			s = longint'($signed(a)) + longint'($signed(b));
			if (s > 64'sd2147483647) return 32'h7fff_ffff;
			if (s < -64'sd2147483648) return 32'h8000_0000;
			return s[31:0];
		end
	endfunction

	// shift the value store up and place v at pos
	function automatic void store_insert(int pos, logic [31:0] v);
		begin
			for (int k = pr_nvals; k > pos; k--) pr_vals[k] = pr_vals[k-1];
			pr_vals[pos] = v;
			pr_nvals++;
		end
	endfunction

	function automatic answer_t predict_sum(request_t rq);
		answer_t a;
		int base;
		int s;
		int e;
		int i;
		bit found;
		begin
			a.sum = '0;
			i = int'(rq.idx);
			base = 0;
			found = 0;
			if (rq.op == OP_CLEAR) begin
				pr_runs = 0;
				pr_nvals = 0;
				a.st = ST_CLEARED;
			end else if (rq.op == OP_ACC) begin
				for (int r = 0; r < pr_runs && !found; r++) begin
					s = int'(pr_start[r]);
					e = s + int'(pr_len[r]);
					if ((s == 0 || s - 1 <= i) && e >= i) begin
						found = 1;
						if (s > 0 && s - 1 == i) begin
							if (pr_nvals >= NumVals) a.st = ST_DROPPED;
							else begin
								pr_start[r] = 16'(s - 1);
								pr_len[r]++;
								store_insert(base, rq.val);
								a.st = ST_FRONT;
								a.sum = rq.val;
							end
						end else if (i < e) begin
							pr_vals[base+i-s] = clamp_add(pr_vals[base+i-s], rq.val);
							a.st = ST_ADDED;
							a.sum = pr_vals[base+i-s];
						end else if (pr_nvals >= NumVals) a.st = ST_DROPPED;
						else begin
							store_insert(base + int'(pr_len[r]), rq.val);
							pr_len[r]++;
							a.st = ST_BACK;
							a.sum = rq.val;
						end
					end
					base += int'(pr_len[r]);
				end
				if (!found) begin
					if (pr_runs >= NumRuns || pr_nvals >= NumVals) a.st = ST_DROPPED;
					else begin
						pr_start[pr_runs] = rq.idx;
						pr_len[pr_runs] = 7'd1;
						pr_runs++;
						pr_vals[pr_nvals] = rq.val;
						pr_nvals++;
						a.st = ST_NEW;
						a.sum = rq.val;
					end
				end
			end else begin
				// read and the unused opcode sum every run holding the index
				for (int r = 0; r < pr_runs; r++) begin
					s = int'(pr_start[r]);
					if (s <= i && i < s + int'(pr_len[r])) begin
						a.sum = clamp_add(a.sum, pr_vals[base+i-s]);
						found = 1;
					end
					base += int'(pr_len[r]);
				end
				a.st = found ? ST_HIT : ST_MISS;
				if (!found) a.sum = '0;
			end
			a.runs = pr_runs[4:0];
			a.vals = pr_nvals[6:0];
			return a;
		end
	endfunction

	function automatic request_t mk(opcode_t op, int idx, logic [31:0] v);
		request_t rq;
		begin
			rq.op = op;
			rq.idx = idx[15:0];
			rq.val = v;
			return rq;
		end
	endfunction

	// driver: bursts and gaps, one nonblocking write per signal per edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			opcode <= '0;
			windex <= '0;
			value <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else if (!(start && busy)) begin
			// a high start here means the request is taken at this edge
			if (start && burst_left <= 1) begin
				burst_left <= $urandom_range(1, 12);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			end else if (start) burst_left <= burst_left - 1;
			else if (gap_left > 0) gap_left <= gap_left - 1;
			if ((start && burst_left <= 1) || (!start && gap_left > 0) || hold_off
					|| pending.size() == 0) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				opcode <= pending[0].op;
				windex <= pending[0].idx;
				value <= pending[0].val;
				expected.push_back(predict_sum(pending[0]));
				void'(pending.pop_front());
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result status=%0d", status);
			end else begin
				if (status !== expected[0].st || sum_out !== expected[0].sum
						|| run_count !== expected[0].runs || value_count !== expected[0].vals) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp st=%0d sum=%h runs=%0d vals=%0d",
							expected[0].st, expected[0].sum, expected[0].runs, expected[0].vals);
						$display("         got st=%0d sum=%h runs=%0d vals=%0d",
							status, sum_out, run_count, value_count);
					end
				end
				void'(expected.pop_front());
			end
		end
	end

	initial begin
		int base_idx;
		int n;
		int pick;
		mismatches = 0;
		hold_off = 0;
		pr_runs = 0;
		pr_nvals = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed: index 0 and max, saturation both ways, grows, reads, clear, opcode 3
		pending.push_back(mk(OP_READ, 5, 0));
		pending.push_back(mk(OP_ACC, 0, 32'h7fff_0000));
		pending.push_back(mk(OP_ACC, 0, 32'h7fff_ffff));
		pending.push_back(mk(OP_ACC, 1, 32'h8000_0000));
		pending.push_back(mk(OP_ACC, 1, 32'h8000_0000));
		pending.push_back(mk(OP_ACC, 65535, 32'hffff_ffff));
		pending.push_back(mk(OP_ACC, 65534, 32'h0001_0000));
		pending.push_back(mk(OP_ACC, 100, 32'h0000_0001));
		pending.push_back(mk(OP_ACC, 102, 32'h0000_0002));
		pending.push_back(mk(OP_ACC, 101, 32'h0000_0003));
		pending.push_back(mk(OP_ACC, 103, 32'h0000_0004));
		pending.push_back(mk(OP_READ, 101, 0));
		pending.push_back(mk(OP_RSVD, 103, 32'hffff_ffff));
		pending.push_back(mk(OP_READ, 65535, 0));
		pending.push_back(mk(OP_READ, 200, 0));
		pending.push_back(mk(OP_CLEAR, 65535, 32'hffff_ffff));
		pending.push_back(mk(OP_READ, 0, 0));
		// fill the run table to the drop case
		for (int k = 0; k < 17; k++) pending.push_back(mk(OP_ACC, 1000 + 3 * k, k));
		pending.push_back(mk(OP_ACC, 1000, 32'h1));
		pending.push_back(mk(OP_CLEAR, 0, 0));
		// random sessions: dense clusters grow runs and fill the value store
		n = 0;
		while (n < 1300) begin
			base_idx = ($urandom_range(0, 7) == 0) ? $urandom_range(65500, 65535)
				: ($urandom_range(0, 7) == 0 ? $urandom_range(0, 4) : $urandom_range(0, 65535));
			for (int k = 0; k < 80 && n < 1300; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 2) pending.push_back(mk(OP_CLEAR, $urandom, $urandom));
				else if (pick < 20)
					pending.push_back(mk(pick < 5 ? OP_RSVD : OP_READ,
						base_idx + $urandom_range(0, 20) - 3, $urandom));
				else if (pick < 25) pending.push_back(mk(OP_ACC, $urandom, $urandom));
				else pending.push_back(mk(OP_ACC, base_idx + $urandom_range(0, 20) - 3,
					($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h3ffff)
						- 32'h1ffff));
				n++;
			end
			if ($urandom_range(0, 1)) pending.push_back(mk(OP_CLEAR, 0, 0));
			if (n > 600 && n < 700) begin
				// pause until all outstanding results are in
				wait (pending.size() == 0);
				hold_off = 1;
				wait (expected.size() == 0);
				hold_off = 0;
			end
		end
		wait (pending.size() == 0 && !start);
		// separate hold-off once everything queued
		hold_off = 1;
		wait (expected.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected.size() == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end

	initial begin
		#20000000;
		$display("tb: errors");
		$finish;
	end

endmodule
